/* rtl/acm_pkg.sv */
// Shared types, widths and the coefficient table for the anaglyph color matrix.
// Used by every module of the block and by its port checker; no dependencies.
package acm_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
  localparam int PSUM_W    = PROD_W + 2;
  localparam int ACC_W     = PSUM_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = ACC_W - FRAC_BITS;
  localparam int NUM_ROWS  = 3;
  localparam int NUM_TAPS  = 6;
  localparam int NUM_HALF  = 2;
  localparam int HALF_TAPS = NUM_TAPS / NUM_HALF;
  localparam int NUM_MODES = 12;
  localparam int NUM_STAGES = 4;

  typedef logic [3:0] mode_t;
  localparam mode_t MODE_RESET = 4'd3;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [PSUM_W-1:0]   psum_t;

  typedef sample_t sample_vec_t [NUM_TAPS];
  typedef coef_t   coef_mat_t   [NUM_ROWS][NUM_TAPS];
  typedef prod_t   prod_mat_t   [NUM_ROWS][NUM_TAPS];
  typedef psum_t   psum_mat_t   [NUM_ROWS][NUM_HALF];

  typedef struct packed {
    sample_t left_red;
    sample_t left_green;
    sample_t left_blue;
    sample_t right_red;
    sample_t right_green;
    sample_t right_blue;
  } pixel_in_t;

  typedef struct packed {
    sample_t out_red;
    sample_t out_green;
    sample_t out_blue;
  } pixel_out_t;

  // Rows: output red, green, blue. Columns: left r,g,b then right r,g,b. Signed Q2.16 format.
  localparam coef_t COEF_TABLE [NUM_MODES][NUM_ROWS][NUM_TAPS] = '{
    // red/cyan gray
    '{'{18'sd19595, 18'sd38470, 18'sd7471, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd19595, 18'sd38470, 18'sd7471},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd19595, 18'sd38470, 18'sd7471}},
    // red/cyan half color
    '{'{18'sd19595, 18'sd38470, 18'sd7471, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536}},
    // red/cyan color
    '{'{18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536}},
    // red/cyan Dubois
    '{'{18'sd29891, 18'sd32800, 18'sd11559, -18'sd2849, -18'sd5763, -18'sd102},
      '{-18'sd2627, -18'sd2479, -18'sd1033, 18'sd24804, 18'sd48080, -18'sd1209},
      '{-18'sd997, -18'sd1350, -18'sd358, -18'sd4729, -18'sd7403, 18'sd80373}},
    // green/magenta gray
    '{'{18'sd0, 18'sd0, 18'sd0, 18'sd19595, 18'sd38470, 18'sd7471},
      '{18'sd19595, 18'sd38470, 18'sd7471, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd19595, 18'sd38470, 18'sd7471}},
    // green/magenta half color
    '{'{18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0},
      '{18'sd19595, 18'sd38470, 18'sd7471, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536}},
    // green/magenta color
    '{'{18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536}},
    // green/magenta Dubois
    '{'{-18'sd4063, -18'sd10354, -18'sd2556, 18'sd34669, 18'sd46203, 18'sd1573},
      '{18'sd18612, 18'sd43778, 18'sd9372, -18'sd1049, -18'sd983, -18'sd4260},
      '{-18'sd983, -18'sd1769, 18'sd1376, 18'sd590, 18'sd4915, 18'sd61407}},
    // yellow/blue gray
    '{'{18'sd0, 18'sd0, 18'sd0, 18'sd19595, 18'sd38470, 18'sd7471},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd19595, 18'sd38470, 18'sd7471},
      '{18'sd19595, 18'sd38470, 18'sd7471, 18'sd0, 18'sd0, 18'sd0}},
    // yellow/blue half color
    '{'{18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0},
      '{18'sd19595, 18'sd38470, 18'sd7471, 18'sd0, 18'sd0, 18'sd0}},
    // yellow/blue color
    '{'{18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0}},
    // yellow/blue Dubois
    '{'{18'sd65535, -18'sd12650, 18'sd18451, -18'sd987, -18'sd7590, -18'sd1049},
      '{-18'sd1604, 18'sd56032, 18'sd4196, 18'sd370, 18'sd3826, -18'sd1049},
      '{-18'sd2345, -18'sd10676, 18'sd1358, 18'sd5801, 18'sd11416, 18'sd56217}}
  };

  // Unused mode codes select an all-zero matrix.
  function automatic coef_t coef_lookup(mode_t mode, logic [1:0] row, logic [2:0] col);
    coef_t c;
    if (mode < mode_t'(NUM_MODES)) begin
      c = COEF_TABLE[mode][row][col];
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

/* rtl/acm_coef_stage.sv */
// First pipeline stage: registers the pixel pair as six samples and looks up
// the 3x6 coefficient matrix of the current mode. Depends on acm_pkg.
module acm_coef_stage (
  input  logic                  clk,
  input  logic                  load,
  input  acm_pkg::mode_t        mode,
  input  acm_pkg::pixel_in_t    pix,
  output acm_pkg::sample_vec_t  samples,
  output acm_pkg::coef_mat_t    coefs
);

  acm_pkg::sample_vec_t samples_next;

  always_comb begin
    samples_next[0] = pix.left_red;
    samples_next[1] = pix.left_green;
    samples_next[2] = pix.left_blue;
    samples_next[3] = pix.right_red;
    samples_next[4] = pix.right_green;
    samples_next[5] = pix.right_blue;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < acm_pkg::NUM_ROWS; r++) begin
        for (int c = 0; c < acm_pkg::NUM_TAPS; c++) begin
          coefs[r][c] <= acm_pkg::coef_lookup(mode, 2'(r), 3'(c));
        end
      end
      for (int c = 0; c < acm_pkg::NUM_TAPS; c++) begin
        samples[c] <= samples_next[c];
      end
    end
  end

endmodule

/* rtl/acm_mult_stage.sv */
// Second pipeline stage: eighteen signed coefficient-by-sample products.
// Depends on acm_pkg.
module acm_mult_stage (
  input  logic                  clk,
  input  logic                  load,
  input  acm_pkg::sample_vec_t  samples,
  input  acm_pkg::coef_mat_t    coefs,
  output acm_pkg::prod_mat_t    prods
);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < acm_pkg::NUM_ROWS; r++) begin
        for (int c = 0; c < acm_pkg::NUM_TAPS; c++) begin
          // zero-extend the sample so the product stays signed
          prods[r][c] <= coefs[r][c] * $signed({1'b0, samples[c]});
        end
      end
    end
  end

endmodule

/* rtl/acm_sum_stage.sv */
// Third pipeline stage: adds the left-eye and right-eye product triples of
// each output channel into two partial sums. Depends on acm_pkg.
module acm_sum_stage (
  input  logic                clk,
  input  logic                load,
  input  acm_pkg::prod_mat_t  prods,
  output acm_pkg::psum_mat_t  psums
);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int r = 0; r < acm_pkg::NUM_ROWS; r++) begin
        for (int h = 0; h < acm_pkg::NUM_HALF; h++) begin
          psums[r][h] <= acm_pkg::PSUM_W'(prods[r][h*acm_pkg::HALF_TAPS])
                       + acm_pkg::PSUM_W'(prods[r][h*acm_pkg::HALF_TAPS + 1])
                       + acm_pkg::PSUM_W'(prods[r][h*acm_pkg::HALF_TAPS + 2]);
        end
      end
    end
  end

endmodule

/* rtl/acm_clamp_stage.sv */
// Fourth pipeline stage and output register: final sum per channel, drop the
// 16 fraction bits and clamp to 0..255. Depends on acm_pkg.
module acm_clamp_stage (
  input  logic                clk,
  input  logic                load,
  input  acm_pkg::psum_mat_t  psums,
  output acm_pkg::pixel_out_t pix
);

  localparam logic [acm_pkg::Q_W-1:0] Q_MAX = acm_pkg::Q_W'(255);

  logic signed [acm_pkg::ACC_W-1:0] acc   [acm_pkg::NUM_ROWS];
  logic        [acm_pkg::Q_W-1:0]   q     [acm_pkg::NUM_ROWS];
  acm_pkg::sample_t                 chan  [acm_pkg::NUM_ROWS];
  acm_pkg::pixel_out_t              pix_next;

  always_comb begin
    for (int r = 0; r < acm_pkg::NUM_ROWS; r++) begin
      acc[r] = acm_pkg::ACC_W'(psums[r][0]) + acm_pkg::ACC_W'(psums[r][1]);
      q[r]   = acc[r][acm_pkg::ACC_W-1:acm_pkg::FRAC_BITS];
      if (acc[r][acm_pkg::ACC_W-1]) begin
        chan[r] = '0;
      end else if (q[r] > Q_MAX) begin
        chan[r] = '1;
      end else begin
        chan[r] = q[r][acm_pkg::SAMPLE_W-1:0];
      end
    end
    pix_next.out_red   = chan[0];
    pix_next.out_green = chan[1];
    pix_next.out_blue  = chan[2];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix <= pix_next;
    end
  end

endmodule

/* rtl/anaglyph_color_matrix.sv */
// Top level of the anaglyph color matrix: mode register, pipeline valid bits
// and stall control. Depends on acm_pkg and the four acm_*_stage modules.
//
// Usage:
//   in_valid/in_ready/in_data carry one left/right RGB24 pixel pair per
//   transaction; out_valid/out_ready/out_data return one anaglyph RGB pixel
//   per input transaction, in order.
//   cfg_valid/cfg_ready/cfg_data write the 4-bit coefficient set select;
//   cfg_ready is high whenever the block is out of reset. Write it only while
//   no pixel is in flight. Codes 12..15 give black output.
//   Each accepted input passes through the register stages coefficient
//   lookup, multiply, partial sums, and final sum and clamp. Throughput is
//   one pixel pair per clock while out_ready stays high; the multiply stage
//   with 18 products of 18x9 bits in parallel sets the clock.
//   Each stage holds its transaction only while the stage after it is full
//   and holding, so a stalled receiver freezes the full stages and empty
//   stages keep filling; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and sets the mode to red/cyan
//   Dubois (code 3); in_ready and cfg_ready are low during reset.
module anaglyph_color_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  acm_pkg::pixel_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acm_pkg::pixel_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  acm_pkg::mode_t      cfg_data
);

  acm_pkg::mode_t                 anaglyph_mode;
  logic [acm_pkg::NUM_STAGES-1:0] stage_valid;
  logic [acm_pkg::NUM_STAGES-1:0] stage_load;

  acm_pkg::sample_vec_t   s1_samples;
  acm_pkg::coef_mat_t     s1_coefs;
  acm_pkg::prod_mat_t     s2_prods;
  acm_pkg::psum_mat_t     s3_psums;

  // A stage loads when it is empty or its contents move on this edge.
  always_comb begin
    stage_load[acm_pkg::NUM_STAGES-1] = !stage_valid[acm_pkg::NUM_STAGES-1] || out_ready;
    for (int k = acm_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      stage_load[k] = !stage_valid[k] || stage_load[k+1];
    end
  end

  assign in_ready  = stage_load[0] && !rst;
  assign cfg_ready = !rst;
  assign out_valid = stage_valid[acm_pkg::NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      anaglyph_mode <= acm_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      anaglyph_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_load[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < acm_pkg::NUM_STAGES; k++) begin
        if (stage_load[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  acm_coef_stage u_coef (
    .clk     (clk),
    .load    (stage_load[0]),
    .mode    (anaglyph_mode),
    .pix     (in_data),
    .samples (s1_samples),
    .coefs   (s1_coefs)
  );

  acm_mult_stage u_mult (
    .clk     (clk),
    .load    (stage_load[1]),
    .samples (s1_samples),
    .coefs   (s1_coefs),
    .prods   (s2_prods)
  );

  acm_sum_stage u_sum (
    .clk   (clk),
    .load  (stage_load[2]),
    .prods (s2_prods),
    .psums (s3_psums)
  );

  acm_clamp_stage u_clamp (
    .clk   (clk),
    .load  (stage_load[3]),
    .psums (s3_psums),
    .pix   (out_data)
  );

endmodule

/* rtl/acm_checker.sv */
// Port-level checks for the anaglyph color matrix, bound to the top level.
// Depends on acm_pkg and anaglyph_color_matrix.
module acm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input acm_pkg::pixel_out_t out_data,
  input logic                cfg_ready
);

  // A held result must not change or vanish.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held output transaction changed");

  // With the receiver taking results, the pipeline never blocks the source.
  assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although output drains");

  // A result that appears on an idle output was accepted one pipeline depth earlier.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, acm_pkg::NUM_STAGES))
    else $error("output transaction without matching input");

  // Hold off both input channels during reset.
  assert property (@(posedge clk)
    rst |-> !in_ready && !cfg_ready)
    else $error("channel ready during reset");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pipeline not empty after reset");

endmodule

bind anaglyph_color_matrix acm_checker u_acm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
